// ===== sv/mnpw_pkg.sv =====
// mnpw_pkg: widths, codes and shared types for the nearest-point walk block
// no dependencies; imported by every module of the block except mnpw_ram
package mnpw_pkg;

  // sizes fixed by the request fields
  localparam int MaxPointsDef = 64;
  localparam int CoordW       = 16;
  localparam int DistW        = 17;
  localparam int SqW          = 2 * DistW;
  localparam int MulW         = 17;
  localparam int BetaW        = 16;
  localparam int OpW          = 2;
  localparam int IdxW         = 6;
  localparam int CfgIdxW      = 2;
  localparam int CfgW         = 17;
  localparam int NumPtsW      = 7;

  // configuration reset values
  localparam logic [NumPtsW-1:0] NumPtsReset = NumPtsW'(42);
  localparam logic [DistW-1:0]   CapReset    = {DistW{1'b1}};

  // request operations
  typedef enum logic [OpW-1:0] {
    OpLoad    = 2'd0,
    OpStart   = 2'd1,
    OpPropose = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegNumPoints = 2'd0,
    RegDistCap   = 2'd1
  } cfg_reg_e;

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// ===== sv/metropolis_nearest_point_walk.sv =====
// metropolis_nearest_point_walk: point store, nearest distance scan and walk decision
// depends on mnpw_pkg, mnpw_ram, mnpw_mul and mnpw_sqrt
//
//  channel   handshake          payload
//  request   start_i / busy_o   operation_i point_index_i coord_x_i coord_y_i beta_i
//  result    done_o (strobe)    walk_x_o walk_y_o walk_distance_o accepted_o
//  config    cfg_we_i           cfg_idx_i cfg_wdata_i
//
// a load request is stored in the cycle it is taken and keeps busy_o low.
// a start or propose request scans n points, n = num_points capped at MaxPoints:
// per point the shared multiplier squares dx and dy (states SSqx, SSqy, SAcc), then
// the bit-serial square root produces one root bit per cycle; a proposal that needs
// the beta product adds the SDec state.
// busy_o is high while a request is worked on; done_o marks one result cycle.
// reset is asynchronous and active low; the point store has no reset.
// the receiver cannot stall, so results are never held back.
module metropolis_nearest_point_walk import mnpw_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [OpW-1:0]             operation_i,
  input  logic [IdxW-1:0]            point_index_i,
  input  logic signed [CoordW-1:0]   coord_x_i,
  input  logic signed [CoordW-1:0]   coord_y_i,
  input  logic [BetaW-1:0]           beta_i,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgW-1:0]            cfg_wdata_i,
  output logic                       done_o,
  output logic signed [CoordW-1:0]   walk_x_o,
  output logic signed [CoordW-1:0]   walk_y_o,
  output logic [DistW-1:0]           walk_distance_o,
  output logic                       accepted_o
);

  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW  = $clog2(MaxPoints + 1);

  typedef enum logic [2:0] {
    SIdle,
    SSqx,
    SSqy,
    SAcc,
    SRootGo,
    SRootWait,
    SCand,
    SDec
  } state_e;

  state_e state_q;

  // configuration
  logic [NumPtsW-1:0] cfg_num_q;
  logic [DistW-1:0]   cfg_cap_q;

  // request context
  op_e                op_q;
  logic [CoordW-1:0]  pos_x_q;
  logic [CoordW-1:0]  pos_y_q;
  logic [BetaW-1:0]   beta_q;
  logic [CntW-1:0]    idx_q;
  logic [CntW-1:0]    lim_q;
  logic [SqW-1:0]     min_sq_q;
  logic [SqW-1:0]     sqx_q;
  logic [MulW-1:0]    ay_q;
  logic [DistW-1:0]   cand_q;

  // walk state and result
  logic [CoordW-1:0]  cur_x_q;
  logic [CoordW-1:0]  cur_y_q;
  logic [DistW-1:0]   cur_dist_q;
  logic               done_q;
  logic               accepted_q;

  // ram and shared unit hookup
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic                ram_re;
  logic [AddrW-1:0]    ram_raddr;
  logic [2*CoordW-1:0] ram_rdata;
  logic [MulW-1:0]     mul_a;
  logic [MulW-1:0]     mul_b;
  logic [2*MulW-1:0]   mul_prod;
  sqrt_stat_t          sq_stat;
  logic [DistW-1:0]    sq_root;

  // request decode
  logic               req_take;
  logic               req_walk;
  logic [CntW-1:0]    num_lim;
  logic [CntW-1:0]    idx_nxt;
  logic               scan_last;
  logic [MulW-1:0]    dx;
  logic [MulW-1:0]    dy;
  logic [MulW-1:0]    ax;
  logic [MulW-1:0]    ay;
  logic [SqW-1:0]     dist_sq;
  logic               take_now;
  logic               take_dec;

  assign busy_o   = (state_q != SIdle);
  assign req_take = start_i && !busy_o;
  assign req_walk = req_take && (op_e'(operation_i) == OpStart ||
                                 op_e'(operation_i) == OpPropose);

  // point count limited to the store depth
  always_comb begin
    if (int'(cfg_num_q) > MaxPoints) begin
      num_lim = CntW'(MaxPoints);
    end else begin
      num_lim = CntW'(cfg_num_q);
    end
  end

  assign idx_nxt   = idx_q + 1'b1;
  assign scan_last = (idx_nxt == lim_q);

  // point store access
  always_comb begin
    ram_we    = req_take && op_e'(operation_i) == OpLoad &&
                (int'(point_index_i) < MaxPoints);
    ram_waddr = AddrW'(point_index_i);
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_q == SIdle) begin
      ram_re = req_walk;
    end else if (state_q == SAcc) begin
      ram_re    = !scan_last;
      ram_raddr = idx_nxt[AddrW-1:0];
    end
  end

  mnpw_ram #(
    .Width (2 * CoordW),
    .Depth (MaxPoints)
  ) u_points (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // absolute coordinate differences of the point just read
  always_comb begin
    dx = {ram_rdata[2*CoordW-1], ram_rdata[2*CoordW-1:CoordW]} -
         {pos_x_q[CoordW-1], pos_x_q};
    dy = {ram_rdata[CoordW-1], ram_rdata[CoordW-1:0]} -
         {pos_y_q[CoordW-1], pos_y_q};
    ax = dx[MulW-1] ? (~dx + 1'b1) : dx;
    ay = dy[MulW-1] ? (~dy + 1'b1) : dy;
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      SSqx: begin
        mul_a = ax;
        mul_b = ax;
      end
      SSqy: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      default: begin
        mul_a = MulW'(beta_q);
        mul_b = MulW'(cur_dist_q);
      end
    endcase
  end

  mnpw_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  mnpw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == SRootGo),
    .value_i (min_sq_q),
    .stat_o  (sq_stat),
    .root_o  (sq_root)
  );

  // squared distance of the current point and the acceptance tests
  assign dist_sq  = sqx_q + SqW'(mul_prod);
  assign take_now = (op_q == OpStart) || (cand_q >= cur_dist_q);
  assign take_dec = SqW'(mul_prod) <= SqW'({cand_q, {BetaW{1'b0}}});

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_num_q <= NumPtsReset;
      cfg_cap_q <= CapReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegNumPoints: cfg_num_q <= cfg_wdata_i[NumPtsW-1:0];
        RegDistCap:   cfg_cap_q <= cfg_wdata_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // request context, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_walk) begin
      op_q     <= op_e'(operation_i);
      pos_x_q  <= coord_x_i;
      pos_y_q  <= coord_y_i;
      beta_q   <= beta_i;
      lim_q    <= num_lim;
      min_sq_q <= '1;
    end
    if (state_q == SSqx) begin
      ay_q <= ay;
    end
    if (state_q == SSqy) begin
      sqx_q <= SqW'(mul_prod);
    end
    if (state_q == SAcc && dist_sq < min_sq_q) begin
      min_sq_q <= dist_sq;
    end
    if (state_q == SRootWait && sq_stat.done) begin
      cand_q <= (sq_root < cfg_cap_q) ? sq_root : cfg_cap_q;
    end
  end

  // sequencer, walk state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      idx_q      <= '0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      cur_dist_q <= '0;
      done_q     <= 1'b0;
      accepted_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (req_walk) begin
            idx_q   <= '0;
            state_q <= (num_lim == '0) ? SRootGo : SSqx;
          end
        end
        SSqx: state_q <= SSqy;
        SSqy: state_q <= SAcc;
        SAcc: begin
          idx_q   <= idx_nxt;
          state_q <= scan_last ? SRootGo : SSqx;
        end
        SRootGo: state_q <= SRootWait;
        SRootWait: begin
          if (sq_stat.done) begin
            state_q <= SCand;
          end
        end
        SCand: begin
          if (take_now) begin
            cur_x_q    <= pos_x_q;
            cur_y_q    <= pos_y_q;
            cur_dist_q <= cand_q;
            accepted_q <= 1'b1;
            done_q     <= 1'b1;
            state_q    <= SIdle;
          end else begin
            state_q <= SDec;
          end
        end
        SDec: begin
          if (take_dec) begin
            cur_x_q    <= pos_x_q;
            cur_y_q    <= pos_y_q;
            cur_dist_q <= cand_q;
          end
          accepted_q <= take_dec;
          done_q     <= 1'b1;
          state_q    <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign done_o          = done_q;
  assign walk_x_o        = cur_x_q;
  assign walk_y_o        = cur_y_q;
  assign walk_distance_o = cur_dist_q;
  assign accepted_o      = accepted_q;

  // a result only ends a busy stretch
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without preceding busy cycle");

  // a walk request always occupies the block
  a_walk_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == OpStart || operation_i == OpPropose))
      |=> busy_o)
    else $error("walk request did not set busy");

  // a start position is always taken
  a_start_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && op_q == OpStart) |-> accepted_o)
    else $error("start position not taken");

  // a rejected proposal leaves the walk untouched
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |->
      ($stable(walk_x_o) && $stable(walk_y_o) && $stable(walk_distance_o)))
    else $error("rejected proposal changed the walk state");

  // the square root only runs inside a walk request
  a_root_in_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.busy |-> busy_o)
    else $error("square root running while idle");

endmodule

// ===== sv/mnpw_ram.sv =====
// mnpw_ram: generic single write port, single read port ram with registered read
// no dependencies
module mnpw_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mnpw_mul.sv =====
// mnpw_mul: shared unsigned multiplier with registered product
// depends on mnpw_pkg for operand widths
module mnpw_mul import mnpw_pkg::*; (
  input  logic              clk_i,
  input  logic [MulW-1:0]   a_i,
  input  logic [MulW-1:0]   b_i,
  output logic [2*MulW-1:0] prod_o
);

  logic [2*MulW-1:0] prod_q;

  // one product per cycle, registered
  always_ff @(posedge clk_i) begin
    prod_q <= (2*MulW)'(a_i) * (2*MulW)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/mnpw_sqrt.sv =====
// mnpw_sqrt: bit-serial integer square root, one root bit per cycle
// depends on mnpw_pkg for widths and the status struct
module mnpw_sqrt import mnpw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   value_i,
  output sqrt_stat_t       stat_o,
  output logic [DistW-1:0] root_o
);

  localparam int RemW = DistW + 1;
  localparam int CntW = $clog2(DistW);

  logic [SqW-1:0]   val_q;
  logic [RemW-1:0]  rem_q;
  logic [DistW-1:0] root_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic             done_q;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             fits;

  // one restoring step on the next bit pair
  always_comb begin
    rem_sh = {rem_q, val_q[SqW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = rem_sh >= trial;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DistW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      val_q <= {val_q[SqW-3:0], 2'b00};
      if (fits) begin
        rem_q  <= RemW'(rem_sh - trial);
        root_q <= {root_q[DistW-2:0], 1'b1};
      end else begin
        rem_q  <= RemW'(rem_sh);
        root_q <= {root_q[DistW-2:0], 1'b0};
      end
    end
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for the nearest-point Metropolis walk block
// depends on mnpw_pkg and metropolis_nearest_point_walk; drives requests and register
// writes, predicts each walk step and checks every result strobe against it
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mnpw_pkg::*;

  // codes the package leaves unnamed
  localparam logic [OpW-1:0]     OpUnused    = 2'd3;
  localparam logic [CfgIdxW-1:0] RegSpare    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareTop = 2'd3;

  localparam int LoadSettle  = 4;
  localparam int TailCycles  = 3 * MaxPointsDef + 40;
  localparam int IdleLimit   = 2000;
  localparam int PhaseLength = 125;

  typedef struct {
    logic [OpW-1:0]           op;
    logic [IdxW-1:0]          idx;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [BetaW-1:0]         beta;
    logic                     drain;
  } walk_req_t;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [DistW-1:0]         distance;
    logic                     taken;
  } walk_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [OpW-1:0]           operation_i = '0;
  logic [IdxW-1:0]          point_index_i = '0;
  logic signed [CoordW-1:0] coord_x_i = '0;
  logic signed [CoordW-1:0] coord_y_i = '0;
  logic [BetaW-1:0]         beta_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgW-1:0]          cfg_wdata_i = '0;
  logic                     done_o;
  logic signed [CoordW-1:0] walk_x_o;
  logic signed [CoordW-1:0] walk_y_o;
  logic [DistW-1:0]         walk_distance_o;
  logic                     accepted_o;

  metropolis_nearest_point_walk dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the block: point table, walk position and registers
  logic signed [CoordW-1:0] pt_x [MaxPointsDef];
  logic signed [CoordW-1:0] pt_y [MaxPointsDef];
  logic signed [CoordW-1:0] walk_x = '0;
  logic signed [CoordW-1:0] walk_y = '0;
  logic [DistW-1:0]         walk_dist = '0;
  logic [NumPtsW-1:0]       cfg_points = NumPtsReset;
  logic [DistW-1:0]         cfg_cap = CapReset;

  walk_req_t    pending_req[$];
  walk_result_t expected_walk[$];
  walk_req_t    on_port;

  int gap_pct = 23;
  int items_queued = 0;
  int items_taken = 0;
  int mismatches = 0;
  int stalled = 0;
  int n_loads = 0, n_starts = 0, n_proposals = 0, n_taken = 0, n_unused = 0;
  int n_results = 0, n_settings = 0;
  logic signed [CoordW-1:0] gen_x = '0;
  logic signed [CoordW-1:0] gen_y = '0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // floor of the square root, one result bit per trial
  function automatic logic [DistW-1:0] floor_root(input logic [63:0] v);
    logic [DistW-1:0] root;
    logic [63:0]      trial;
    root = '0;
    for (int b = DistW - 1; b >= 0; b--) begin
      trial = 64'(root) | (64'd1 << b);
      if (trial * trial <= v) root = trial[DistW-1:0];
    end
    return root;
  endfunction

  // distance to the nearest scanned point, starting from the cap
  function automatic logic [DistW-1:0] nearest_distance(input logic signed [CoordW-1:0] x,
                                                         input logic signed [CoordW-1:0] y);
    int               scan;
    logic [DistW-1:0] best;
    logic [DistW-1:0] d;
    longint           dx, dy;
    best = cfg_cap;
    scan = (cfg_points > MaxPointsDef) ? MaxPointsDef : int'(cfg_points);
    for (int i = 0; i < scan; i++) begin
      dx = longint'(pt_x[i]) - longint'(x);
      dy = longint'(pt_y[i]) - longint'(y);
      d  = floor_root(64'(dx * dx + dy * dy));
      if (d < best) best = d;
    end
    return best;
  endfunction

  // one accepted request applied to the shadow; queues the walk result it causes
  task automatic advance_walk(input walk_req_t req);
    logic [DistW-1:0] cand;
    logic             take;
    walk_result_t     res;
    if (req.op == OpLoad) begin
      pt_x[req.idx] = req.x;
      pt_y[req.idx] = req.y;
      n_loads++;
    end else if (req.op == OpStart || req.op == OpPropose) begin
      cand = nearest_distance(req.x, req.y);
      if (req.op == OpStart) begin
        take = 1'b1;
        n_starts++;
      end else begin
        take = (cand >= walk_dist) ||
               (64'(req.beta) * 64'(walk_dist) <= (64'(cand) << 16));
        n_proposals++;
        if (take) n_taken++;
      end
      if (take) begin
        walk_x    = req.x;
        walk_y    = req.y;
        walk_dist = cand;
      end
      res.x        = walk_x;
      res.y        = walk_y;
      res.distance = walk_dist;
      res.taken    = take;
      expected_walk.push_back(res);
    end else begin
      n_unused++;
    end
  endtask

  // request driver: holds a request while busy, idles at random between requests
  always @(posedge clk_i) begin : driver
    walk_req_t nxt;
    logic      go;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (start_i) begin
        advance_walk(on_port);
        items_taken++;
      end
      go = 1'b0;
      if (pending_req.size() > 0 && $urandom_range(99) >= gap_pct) begin
        if (!pending_req[0].drain ||
            (expected_walk.size() == 0 && !busy_o && !done_o)) go = 1'b1;
      end
      if (go) begin
        nxt           = pending_req.pop_front();
        on_port       = nxt;
        operation_i   <= nxt.op;
        point_index_i <= nxt.idx;
        coord_x_i     <= nxt.x;
        coord_y_i     <= nxt.y;
        beta_i        <= nxt.beta;
        start_i       <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin : monitor
    walk_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (expected_walk.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: x %0d y %0d dist %0d",
                                    walk_x_o, walk_y_o, walk_distance_o));
        end else begin
          want = expected_walk.pop_front();
          if (walk_x_o !== want.x)
            report_mismatch($sformatf("result %0d walk_x got %0d expected %0d",
                                      n_results, walk_x_o, want.x));
          if (walk_y_o !== want.y)
            report_mismatch($sformatf("result %0d walk_y got %0d expected %0d",
                                      n_results, walk_y_o, want.y));
          if (walk_distance_o !== want.distance)
            report_mismatch($sformatf("result %0d walk_distance got %0d expected %0d",
                                      n_results, walk_distance_o, want.distance));
          if (accepted_o !== want.taken)
            report_mismatch($sformatf("result %0d accepted got %0b expected %0b",
                                      n_results, accepted_o, want.taken));
        end
      end
      if (done_o || (start_i && !busy_o)) stalled = 0;
      else stalled++;
      if (stalled == IdleLimit) begin
        $display("watchdog: nothing moved for %0d cycles", IdleLimit);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // register write while the block is idle
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    if (idx == RegNumPoints) cfg_points = value[NumPtsW-1:0];
    else if (idx == RegDistCap) cfg_cap = value[DistW-1:0];
    n_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle(input int settle);
    @(negedge clk_i);
    while (!(items_taken == items_queued && expected_walk.size() == 0 && !busy_o))
      @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  function automatic walk_req_t build_request(input logic [OpW-1:0] op,
                                              input logic [IdxW-1:0] idx,
                                              input logic signed [CoordW-1:0] x,
                                              input logic signed [CoordW-1:0] y,
                                              input logic [BetaW-1:0] beta);
    walk_req_t r;
    r.op    = op;
    r.idx   = idx;
    r.x     = x;
    r.y     = y;
    r.beta  = beta;
    r.drain = 1'b0;
    return r;
  endfunction

  task automatic push_request(input walk_req_t r);
    pending_req.push_back(r);
    items_queued++;
  endtask

  // mostly within 4096 units of the origin, now and then anywhere
  function automatic logic signed [CoordW-1:0] cluster_coord();
    int v;
    if ($urandom_range(4) == 0) return CoordW'($urandom);
    v = int'($urandom_range(8191)) - 4096;
    return v[CoordW-1:0];
  endfunction

  function automatic logic signed [CoordW-1:0] step_from(input logic signed [CoordW-1:0] a);
    int v;
    v = int'(a) + int'($urandom_range(1023)) - 512;
    return v[CoordW-1:0];
  endfunction

  // random request: mostly proposals that step away from the last generated position
  function automatic walk_req_t make_walk_request();
    walk_req_t r;
    int        pick;
    pick = $urandom_range(99);
    r = build_request(OpPropose, IdxW'($urandom), '0, '0, BetaW'($urandom));
    if (pick < 8) begin
      r.op = OpLoad;
      r.x  = cluster_coord();
      r.y  = cluster_coord();
    end else if (pick < 12) begin
      r.op = OpUnused;
      r.x  = CoordW'($urandom);
      r.y  = CoordW'($urandom);
    end else if (pick < 22) begin
      r.op  = OpStart;
      r.x   = cluster_coord();
      r.y   = cluster_coord();
      gen_x = r.x;
      gen_y = r.y;
    end else if (pick < 88) begin
      r.x   = step_from(gen_x);
      r.y   = step_from(gen_y);
      gen_x = r.x;
      gen_y = r.y;
    end else begin
      r.x = CoordW'($urandom);
      r.y = CoordW'($urandom);
    end
    return r;
  endfunction

  initial begin : stimulus
    walk_req_t r;
    int        phase_points [6];
    int        phase_cap [6];
    phase_points = '{64, 127, 1, 16, 8, 0};
    phase_cap    = '{131071, 0, 131071, 0, 0, 2048};
    phase_cap[1] = $urandom_range(5000, 60000);
    phase_cap[4] = $urandom_range(131071);
    phase_points[5] = $urandom_range(1, 64);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no points scanned: every score equals the cap
    write_register(RegNumPoints, CfgW'(0));
    write_register(RegDistCap, CfgW'(1000));
    @(negedge clk_i);
    push_request(build_request(OpStart, '0, '0, '0, '0));
    push_request(build_request(OpPropose, '0, 16'h7fff, 16'h8000, 16'h0000));
    push_request(build_request(OpUnused, 6'h3f, 16'hffff, 16'hffff, 16'hffff));
    // corners, origin and one point off the axes
    push_request(build_request(OpLoad, 6'd0, 16'h8000, 16'h8000, 16'h0000));
    push_request(build_request(OpLoad, 6'd1, 16'h7fff, 16'h7fff, 16'hffff));
    push_request(build_request(OpLoad, 6'd2, 16'h0000, 16'h0000, 16'h0000));
    push_request(build_request(OpLoad, 6'd3, 16'h0400, 16'hfc00, 16'h5a5a));
    wait_idle(LoadSettle);

    // four points, full cap; spare register indexes must be ignored
    write_register(RegNumPoints, CfgW'(4));
    write_register(RegDistCap, CapReset);
    write_register(RegSpare, 17'h00005);
    write_register(RegSpareTop, '1);
    @(negedge clk_i);
    push_request(build_request(OpStart, '0, 16'h0000, 16'h0000, 16'h0000));
    // current score zero: any candidate goes through
    push_request(build_request(OpPropose, '0, 16'h0064, 16'h0000, 16'hffff));
    push_request(build_request(OpPropose, '0, 16'h0000, 16'h0000, 16'hffff));
    push_request(build_request(OpPropose, '0, 16'h0000, 16'h0000, 16'h0000));
    push_request(build_request(OpStart, '0, 16'h7fff, 16'h8000, 16'h0000));
    push_request(build_request(OpPropose, '0, 16'h8000, 16'h7fff, 16'hffff));
    push_request(build_request(OpPropose, '0, 16'h0400, 16'hfc00, 16'h8000));
    push_request(build_request(OpPropose, '0, 16'h0410, 16'hfc00, 16'h0001));
    // stale score: a point moves under the walk, the kept score stays
    push_request(build_request(OpLoad, 6'd3, 16'h4000, 16'h4000, 16'h0000));
    push_request(build_request(OpPropose, '0, 16'h0800, 16'hf800, 16'hffff));
    push_request(build_request(OpPropose, '0, 16'h4000, 16'h4000, 16'h7fff));
    wait_idle(LoadSettle);

    // fill every slot so any point count can be scanned
    for (int i = 0; i < MaxPointsDef; i++)
      push_request(build_request(OpLoad, IdxW'(i), cluster_coord(), cluster_coord(),
                                 BetaW'($urandom)));
    wait_idle(LoadSettle);

    // random phases, registers changed between them
    for (int p = 0; p < 6; p++) begin
      gap_pct = (p < 2) ? 23 : (p < 4) ? 60 : 0;
      write_register(RegNumPoints, CfgW'(phase_points[p]));
      write_register(RegDistCap, CfgW'(phase_cap[p]));
      if (p == 1) write_register(RegSpare, CfgW'($urandom));
      @(negedge clk_i);
      for (int k = 0; k < PhaseLength; k++) begin
        r = make_walk_request();
        if (k == 5 || $urandom_range(49) == 0) r.drain = 1'b1;
        push_request(r);
      end
      wait_idle(LoadSettle);
    end

    wait_idle(TailCycles);
    while (expected_walk.size() != 0) begin
      void'(expected_walk.pop_front());
      report_mismatch("walk result never arrived");
    end

    $display("covered %0d loads, %0d starts, %0d proposals (%0d taken), %0d unused codes",
             n_loads, n_starts, n_proposals, n_taken, n_unused);
    $display("%0d results checked across %0d register writes", n_results, n_settings);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
